/* sv/mco_pkg.sv */
// ----------------------------------------------------------------------------
// mco_pkg
// Shared types and codes of the matrix chain order block.
// ----------------------------------------------------------------------------
package mco_pkg;

	localparam int COST_W  = 64;
	localparam int SPLIT_W = 4;
	localparam int DIN_W   = 16;
	localparam int IDX_W   = 5;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic KIND_COST  = 1'b0;
	localparam logic KIND_SPLIT = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [DIN_W-1:0] dim_value;
		logic             last;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} in_word_t;

	typedef struct packed {
		logic               kind;
		logic [COST_W-1:0]  total_cost;
		logic [SPLIT_W-1:0] split_point;
		logic               overflow;
		logic               error;
	} out_word_t;

endpackage

/* sv/matrix_chain_order.sv */
// ----------------------------------------------------------------------------
// matrix_chain_order
// Loads a chain's dimension list, runs the interval dynamic program for the
// least multiplication cost, and answers split table queries.
// ----------------------------------------------------------------------------
//   channel | signals                          | word
//   command | cmd_valid, cmd_stall, cmd_word   | mco_pkg::in_word_t
//   result  | res_valid, res_stall, res_word   | mco_pkg::out_word_t
//
// A load, a bad query or a query with row equal to col is handled in ST_IDLE; any other
// split query also passes ST_QRD (split memory read). The last load of a chain of two or
// more matrices starts the computation: each interval i..j runs ST_RDA to ST_PIJ, ST_K0
// to ST_K5 per split k and ST_WR, paced by the one shared DIM_BITS x DIM_BITS multiplier
// and the single read port of the cost memory; cmd_stall stays high meanwhile.
// Reset clears the counters and flags only; no clearing pass of the tables.
// cmd_stall is also high while a finished word waits on a stalled result side.
// ----------------------------------------------------------------------------
module matrix_chain_order #(
	parameter int MAX_MATRICES = 16,
	parameter int DIM_BITS     = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  mco_pkg::in_word_t  cmd_word,
	output logic               res_valid,
	input  logic               res_stall,
	output mco_pkg::out_word_t res_word
);

	localparam int SLOTS = MAX_MATRICES + 1;
	localparam int CELLS = MAX_MATRICES * MAX_MATRICES;
	localparam int AW    = $clog2(SLOTS);
	localparam int CW    = $clog2(CELLS);
	localparam int IW    = $clog2(MAX_MATRICES + 1);
	localparam int NW    = $clog2(SLOTS + 2);
	localparam int QW    = (IW > mco_pkg::IDX_W) ? IW : mco_pkg::IDX_W;
	localparam int D     = DIM_BITS;
	localparam int DIN   = (D < mco_pkg::DIN_W) ? D : mco_pkg::DIN_W;
	localparam int PW    = 3 * D;
	localparam int CSTW  = mco_pkg::COST_W;

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_QRD   = 13'b0000000000010,
		ST_RDA   = 13'b0000000000100,
		ST_RDB   = 13'b0000000001000,
		ST_MULIJ = 13'b0000000010000,
		ST_PIJ   = 13'b0000000100000,
		ST_K0    = 13'b0000001000000,
		ST_K1    = 13'b0000010000000,
		ST_K2    = 13'b0000100000000,
		ST_K3    = 13'b0001000000000,
		ST_K4    = 13'b0010000000000,
		ST_K5    = 13'b0100000000000,
		ST_WR    = 13'b1000000000000
	} state_t;

	function automatic logic [CW-1:0] cell_addr(input logic [IW-1:0] i,
	                                            input logic [IW-1:0] j);
		return CW'(CW'(i - 1'b1) * CW'(MAX_MATRICES)) + CW'(j - 1'b1);
	endfunction

	state_t state_q;

	logic [NW-1:0]   count_q;
	logic [IW-1:0]   n_q;
	logic            overflow_q;
	logic [IW-1:0]   len_q, i_q, j_q, k_q;
	logic [D-1:0]    pa_q, pk_q;
	logic [2*D-1:0]  pij_q, lo_q;
	logic [PW-1:0]   prod_q;
	logic [CSTW-1:0] c1_q, sum_q, best_q;
	logic            sat_q, best_sat_q;
	logic [IW-1:0]   best_k_q;

	mco_pkg::out_word_t res_q, res_n;
	logic               res_valid_q, res_load;

	// Memory ports.
	logic                       dim_we;
	logic [AW-1:0]              dim_waddr, dim_raddr;
	logic [D-1:0]               dim_wdata, dim_rdata;
	logic                       tab_we;
	logic [CW-1:0]              cost_raddr, split_raddr, tab_waddr;
	logic [CSTW-1:0]            cost_rdata;
	logic [mco_pkg::SPLIT_W-1:0] split_rdata;

	logic [D-1:0]   mul_a, mul_b;
	logic [2*D-1:0] mul_q;

	mco_ram #(.WIDTH(D), .DEPTH(SLOTS)) u_dim_ram (
		.clk(clk), .we(dim_we), .waddr(dim_waddr), .wdata(dim_wdata),
		.raddr(dim_raddr), .rdata(dim_rdata)
	);

	mco_ram #(.WIDTH(CSTW), .DEPTH(CELLS)) u_cost_ram (
		.clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(best_q),
		.raddr(cost_raddr), .rdata(cost_rdata)
	);

	mco_ram #(.WIDTH(mco_pkg::SPLIT_W), .DEPTH(CELLS)) u_split_ram (
		.clk(clk), .we(tab_we), .waddr(tab_waddr),
		.wdata(mco_pkg::SPLIT_W'(best_k_q)),
		.raddr(split_raddr), .rdata(split_rdata)
	);

	mco_mul #(.W(D)) u_mul (
		.clk(clk), .a(mul_a), .b(mul_b), .p_q(mul_q)
	);

	// Command decode.
	logic          accept, is_load, is_query;
	logic [NW-1:0] count_n;
	logic          chain_bad;
	logic [QW-1:0] row_x, col_x, n_x;
	logic          query_bad;
	logic [IW-1:0] row_i, col_i;

	assign cmd_stall = (state_q != ST_IDLE) || (res_valid_q && res_stall);
	assign accept    = cmd_valid && !cmd_stall;
	assign is_load   = accept && (cmd_word.cmd == mco_pkg::CMD_LOAD);
	assign is_query  = accept && (cmd_word.cmd == mco_pkg::CMD_QUERY);

	assign count_n   = (count_q < NW'(SLOTS)) ? count_q + 1'b1 : NW'(SLOTS + 1);
	assign chain_bad = (count_n < NW'(2)) || (count_n > NW'(SLOTS));

	assign row_x = QW'(cmd_word.row);
	assign col_x = QW'(cmd_word.col);
	assign n_x   = QW'(n_q);
	assign query_bad = (n_q == '0) || (row_x == '0) || (col_x == '0) ||
	                   (row_x > n_x) || (col_x > n_x) || (row_x > col_x);
	assign row_i = IW'(cmd_word.row);
	assign col_i = IW'(cmd_word.col);

	assign dim_we      = is_load && (count_q < NW'(SLOTS));
	assign dim_waddr   = AW'(count_q);
	assign dim_wdata   = D'(cmd_word.dim_value[DIN-1:0]);
	assign split_raddr = cell_addr(row_i, col_i);
	assign tab_we      = (state_q == ST_WR);
	assign tab_waddr   = cell_addr(i_q, j_q);

	// Read addresses and multiplier operands follow the sequencer step.
	always_comb begin
		dim_raddr  = AW'(k_q);
		cost_raddr = cell_addr(i_q, k_q);
		mul_a      = pij_q[2*D-1:D];
		mul_b      = pk_q;
		unique case (state_q)
			ST_RDA:   dim_raddr = AW'(i_q - 1'b1);
			ST_RDB:   dim_raddr = AW'(j_q);
			ST_K1:    cost_raddr = cell_addr(k_q + 1'b1, j_q);
			ST_MULIJ: begin
				mul_a = pa_q;
				mul_b = dim_rdata;
			end
			ST_K2:    mul_a = pij_q[D-1:0];
			default: begin
			end
		endcase
	end

	// Second cost add and compare against the running best.
	logic [CSTW:0]   add2;
	logic [CSTW-1:0] cand;
	logic            cand_sat;
	logic            take;

	assign add2     = {1'b0, sum_q} + (CSTW + 1)'(prod_q);
	assign cand     = add2[CSTW] ? '1 : add2[CSTW-1:0];
	assign cand_sat = sat_q | add2[CSTW];
	assign take     = (k_q == i_q) || (cand < best_q);

	logic [CSTW-1:0] c2;
	logic [CSTW:0]   add1;

	assign c2   = (k_q + 1'b1 == j_q) ? '0 : cost_rdata;
	assign add1 = {1'b0, c1_q} + {1'b0, c2};

	// Result word selection. A good chain of two or more matrices answers
	// only when its last interval is written.
	always_comb begin
		res_load = 1'b0;
		res_n    = '0;
		if (is_load && cmd_word.last && (chain_bad || (count_n == NW'(2)))) begin
			res_load       = 1'b1;
			res_n.kind     = mco_pkg::KIND_COST;
			res_n.error    = chain_bad;
		end else if (is_query && (query_bad || (row_x == col_x))) begin
			res_load       = 1'b1;
			res_n.kind     = mco_pkg::KIND_SPLIT;
			res_n.overflow = overflow_q;
			res_n.error    = query_bad;
		end else if (state_q == ST_QRD) begin
			res_load          = 1'b1;
			res_n.kind        = mco_pkg::KIND_SPLIT;
			res_n.split_point = split_rdata;
			res_n.overflow    = overflow_q;
		end else if ((state_q == ST_WR) && (j_q == n_q) && (len_q == n_q)) begin
			res_load         = 1'b1;
			res_n.kind       = mco_pkg::KIND_COST;
			res_n.total_cost = best_q;
			res_n.overflow   = overflow_q | best_sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			n_q         <= '0;
			overflow_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (is_load) begin
						count_q <= cmd_word.last ? '0 : count_n;
						if (cmd_word.last) begin
							overflow_q <= 1'b0;
							if (chain_bad) begin
								n_q <= '0;
							end else begin
								n_q <= IW'(count_n - 1'b1);
								// A single matrix costs nothing; longer chains run.
								if (count_n != NW'(2)) begin
									state_q <= ST_RDA;
								end
							end
						end
					end else if (is_query && !query_bad && (row_x != col_x)) begin
						state_q <= ST_QRD;
					end
				end
				ST_QRD:   state_q <= ST_IDLE;
				ST_RDA:   state_q <= ST_RDB;
				ST_RDB:   state_q <= ST_MULIJ;
				ST_MULIJ: state_q <= ST_PIJ;
				ST_PIJ:   state_q <= ST_K0;
				ST_K0:    state_q <= ST_K1;
				ST_K1:    state_q <= ST_K2;
				ST_K2:    state_q <= ST_K3;
				ST_K3:    state_q <= ST_K4;
				ST_K4:    state_q <= ST_K5;
				ST_K5:    state_q <= (k_q + 1'b1 == j_q) ? ST_WR : ST_K0;
				ST_WR: begin
					overflow_q <= overflow_q | best_sat_q;
					if ((j_q == n_q) && (len_q == n_q)) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_RDA;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_n;
		end
		if (is_load && cmd_word.last) begin
			len_q <= IW'(2);
			i_q   <= IW'(1);
			j_q   <= IW'(2);
		end
		unique case (state_q)
			ST_RDB: pa_q <= dim_rdata;
			ST_PIJ: begin
				pij_q <= mul_q;
				k_q   <= i_q;
			end
			ST_K1: begin
				pk_q <= dim_rdata;
				c1_q <= (k_q == i_q) ? '0 : cost_rdata;
			end
			ST_K2: begin
				sum_q <= add1[CSTW] ? '1 : add1[CSTW-1:0];
				sat_q <= add1[CSTW];
			end
			ST_K3: lo_q <= mul_q;
			ST_K4: prod_q <= (PW'(mul_q) << D) + PW'(lo_q);
			ST_K5: begin
				if (take) begin
					best_q     <= cand;
					best_sat_q <= cand_sat;
					best_k_q   <= k_q;
				end
				k_q <= k_q + 1'b1;
			end
			ST_WR: begin
				if (j_q == n_q) begin
					len_q <= len_q + 1'b1;
					i_q   <= IW'(1);
					j_q   <= len_q + 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
					j_q <= j_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_q;

endmodule

/* sv/mco_ram.sv */
// ----------------------------------------------------------------------------
// mco_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mco_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/mco_mul.sv */
// ----------------------------------------------------------------------------
// mco_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module mco_mul #(
	parameter int W = 16
) (
	input  logic           clk,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [2*W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= (2*W)'(a) * (2*W)'(b);
	end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for matrix_chain_order. A scoreboard class solves each
// loaded chain by the interval dynamic program at the block's widths and
// queues the words the block must return. Tasks send directed and random
// chains, split queries and malformed sequences while both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	class chain_scoreboard;
		logic [mco_pkg::DIN_W-1:0]   dims [0:16];
		logic [mco_pkg::COST_W-1:0]  cost_cell [0:255];
		logic [mco_pkg::SPLIT_W-1:0] split_cell [0:255];
		int unsigned                 dim_count;
		int unsigned                 chain_len;
		bit                          ovf_seen;
		mco_pkg::out_word_t          awaited_words [$];
		int unsigned                 mismatches;
		int unsigned                 chains_solved;
		int unsigned                 split_answers;
		int unsigned                 error_words;

		function new();
			dim_count     = 0;
			chain_len     = 0;
			ovf_seen      = 1'b0;
			mismatches    = 0;
			chains_solved = 0;
			split_answers = 0;
			error_words   = 0;
		endfunction

		function int unsigned cell_index(int unsigned i, int unsigned j);
			return ((i - 1) * 16 + (j - 1)) % 256;
		endfunction

		// Least cost over all intervals; on a tie the first split wins.
		function void solve_chain(int unsigned n);
			int unsigned                span, i, j, k, best_k;
			logic [mco_pkg::COST_W-1:0] best, c, prod;
			logic [mco_pkg::COST_W:0]   s;
			bit                         sat, best_sat;
			for (i = 1; i <= n; i++) begin
				cost_cell[cell_index(i, i)]  = '0;
				split_cell[cell_index(i, i)] = '0;
			end
			for (span = 2; span <= n; span++) begin
				for (i = 1; i + span - 1 <= n; i++) begin
					j        = i + span - 1;
					best     = '0;
					best_sat = 1'b0;
					best_k   = i;
					for (k = i; k < j; k++) begin
						sat  = 1'b0;
						prod = 64'(dims[i - 1]) * 64'(dims[k]) * 64'(dims[j]);
						s = {1'b0, cost_cell[cell_index(i, k)]} +
						    {1'b0, cost_cell[cell_index(k + 1, j)]};
						if (s[mco_pkg::COST_W]) begin
							sat = 1'b1;
							c   = '1;
						end else begin
							c = s[mco_pkg::COST_W-1:0];
						end
						s = {1'b0, c} + {1'b0, prod};
						if (s[mco_pkg::COST_W]) begin
							sat = 1'b1;
							c   = '1;
						end else begin
							c = s[mco_pkg::COST_W-1:0];
						end
						if (k == i || c < best) begin
							best     = c;
							best_sat = sat;
							best_k   = k;
						end
					end
					cost_cell[cell_index(i, j)]  = best;
					split_cell[cell_index(i, j)] = mco_pkg::SPLIT_W'(best_k);
					if (best_sat)
						ovf_seen = 1'b1;
				end
			end
		endfunction

		function void note_command(mco_pkg::in_word_t w);
			mco_pkg::out_word_t e;
			int unsigned        count;
			e = '0;
			if (w.cmd == mco_pkg::CMD_LOAD) begin
				if (dim_count < 17) begin
					dims[dim_count] = w.dim_value;
					dim_count++;
				end else begin
					dim_count = 18;
				end
				if (w.last) begin
					count     = dim_count;
					dim_count = 0;
					ovf_seen  = 1'b0;
					e.kind    = mco_pkg::KIND_COST;
					if (count < 2 || count > 17) begin
						chain_len = 0;
						e.error   = 1'b1;
						error_words++;
					end else begin
						chain_len = count - 1;
						solve_chain(chain_len);
						e.total_cost = cost_cell[cell_index(1, chain_len)];
						e.overflow   = ovf_seen;
						chains_solved++;
					end
					awaited_words = {awaited_words, e};
				end
			end else begin
				e.kind     = mco_pkg::KIND_SPLIT;
				e.overflow = ovf_seen;
				if (chain_len == 0 || w.row < 1 || w.col < 1 || w.row > chain_len ||
				    w.col > chain_len || w.row > w.col) begin
					e.error = 1'b1;
					error_words++;
				end else begin
					if (w.row != w.col)
						e.split_point = split_cell[cell_index(w.row, w.col)];
					split_answers++;
				end
				awaited_words = {awaited_words, e};
			end
		endfunction

		function void compare_field(string name, logic [mco_pkg::COST_W-1:0] exp_v,
		                            logic [mco_pkg::COST_W-1:0] act_v);
			if (act_v !== exp_v) begin
				mismatches++;
				$display("%0t ns: %s expected %0d, actual %0d", $time, name, exp_v, act_v);
			end
		endfunction

		function void check_answer(mco_pkg::out_word_t got);
			mco_pkg::out_word_t e;
			if (awaited_words.size() == 0) begin
				mismatches++;
				$display("%0t ns: result word expected none, actual %h", $time, got);
				return;
			end
			e = awaited_words.pop_front();
			compare_field("kind", 64'(e.kind), 64'(got.kind));
			compare_field("total_cost", e.total_cost, got.total_cost);
			compare_field("split_point", 64'(e.split_point), 64'(got.split_point));
			compare_field("overflow", 64'(e.overflow), 64'(got.overflow));
			compare_field("error", 64'(e.error), 64'(got.error));
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cmd_valid = 1'b0;
	logic               cmd_stall;
	mco_pkg::in_word_t  cmd_word = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	mco_pkg::out_word_t res_word;

	chain_scoreboard sb = new();
	int unsigned     words_sent = 0;
	int unsigned     stall_left = 0;
	bit              tx_idle_on = 1'b1;
	bit              rx_idle_on = 1'b1;

	matrix_chain_order DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_word  (cmd_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Both channels are observed here; the receiver also chooses its stalls.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				sb.note_command(cmd_word);
			if (res_valid && !res_stall)
				sb.check_answer(res_word);
		end
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 17) - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	function automatic mco_pkg::in_word_t make_load(logic [mco_pkg::DIN_W-1:0] dim,
	                                                logic last);
		mco_pkg::in_word_t w;
		w.cmd       = mco_pkg::CMD_LOAD;
		w.dim_value = dim;
		w.last      = last;
		w.row       = mco_pkg::IDX_W'($urandom);
		w.col       = mco_pkg::IDX_W'($urandom);
		return w;
	endfunction

	function automatic mco_pkg::in_word_t make_query(logic [mco_pkg::IDX_W-1:0] row,
	                                                 logic [mco_pkg::IDX_W-1:0] col);
		mco_pkg::in_word_t w;
		w.cmd       = mco_pkg::CMD_QUERY;
		w.dim_value = mco_pkg::DIN_W'($urandom);
		w.last      = 1'(($urandom));
		w.row       = row;
		w.col       = col;
		return w;
	endfunction

	// Called right after a rising edge; returns right after the accepting edge.
	task automatic send_word(mco_pkg::in_word_t w);
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word  <= w;
		do @(posedge clk); while (cmd_stall);
		words_sent++;
	endtask

	task automatic drain_results();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited_words.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [mco_pkg::DIN_W-1:0] pick_dim(int unsigned mode);
		int unsigned r;
		r = $urandom_range(0, 99);
		case (mode)
			0: return mco_pkg::DIN_W'($urandom);
			1: return mco_pkg::DIN_W'($urandom_range(1, 20));
			2: begin
				if (r < 70)
					return '1;
				return mco_pkg::DIN_W'($urandom);
			end
			default: begin
				if (r < 15)
					return '0;
				return mco_pkg::DIN_W'($urandom_range(1, 300));
			end
		endcase
	endfunction

	initial begin
		int unsigned seq_no, kind_r, n, mode, q, nq, row, col, extra, idx;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: query with no chain, too few dimensions, a single matrix,
		// extreme dimensions, a tie, and malformed query indices.
		send_word(make_query(5'd1, 5'd1));
		send_word(make_load(16'd9, 1'b1));
		send_word(make_load(16'd5, 1'b0));
		send_word(make_load(16'd7, 1'b1));
		send_word(make_query(5'd1, 5'd1));
		send_word(make_query(5'd1, 5'd2));
		send_word(make_load(16'd1, 1'b0));
		send_word(make_load(16'hFFFF, 1'b0));
		send_word(make_load(16'hFFFF, 1'b0));
		send_word(make_load(16'd1, 1'b1));
		send_word(make_query(5'd1, 5'd3));
		send_word(make_query(5'd2, 5'd3));
		send_word(make_load(16'd2, 1'b0));
		send_word(make_load(16'd2, 1'b0));
		send_word(make_load(16'd2, 1'b0));
		send_word(make_load(16'd2, 1'b1));
		send_word(make_query(5'd1, 5'd3));
		send_word(make_query(5'd0, 5'd1));
		send_word(make_query(5'd3, 5'd2));
		send_word(make_query(5'd31, 5'd31));
		drain_results();

		seq_no = 0;
		while (words_sent < 1650) begin
			seq_no++;
			if (words_sent >= 1500) begin
				tx_idle_on = 1'b0;
				rx_idle_on <= 1'b0;
			end else begin
				tx_idle_on = ($urandom_range(0, 3) != 0);
				rx_idle_on <= ($urandom_range(0, 3) != 0);
			end
			if (seq_no % 25 == 0)
				drain_results();
			kind_r = $urandom_range(0, 99);
			if (kind_r < 75) begin
				// Well-formed chain, now and then a query slipped in between loads.
				q = $urandom_range(0, 99);
				if (q < 5)
					n = 16;
				else if (q < 15)
					n = $urandom_range(7, 15);
				else
					n = $urandom_range(1, 6);
				mode = $urandom_range(0, 3);
				for (idx = 0; idx <= n; idx++) begin
					if ($urandom_range(0, 19) == 0)
						send_word(make_query(mco_pkg::IDX_W'($urandom_range(0, 17)),
						                     mco_pkg::IDX_W'($urandom_range(0, 17))));
					send_word(make_load(pick_dim(mode), idx == n));
				end
				nq = $urandom_range(1, 8);
				for (q = 0; q < nq; q++) begin
					if ($urandom_range(0, 4) != 0) begin
						row = $urandom_range(1, n);
						col = $urandom_range(row, n);
						send_word(make_query(mco_pkg::IDX_W'(row), mco_pkg::IDX_W'(col)));
					end else begin
						send_word(make_query(mco_pkg::IDX_W'($urandom),
						                     mco_pkg::IDX_W'($urandom)));
					end
				end
			end else if (kind_r < 85) begin
				// More dimensions than the store holds.
				extra = $urandom_range(18, 22);
				for (idx = 1; idx <= extra; idx++)
					send_word(make_load(mco_pkg::DIN_W'($urandom), idx == extra));
				send_word(make_query(mco_pkg::IDX_W'($urandom_range(1, 16)),
				                     mco_pkg::IDX_W'($urandom_range(1, 16))));
			end else if (kind_r < 90) begin
				send_word(make_load(mco_pkg::DIN_W'($urandom), 1'b1));
			end else begin
				nq = $urandom_range(1, 4);
				for (q = 0; q < nq; q++)
					send_word(make_query(mco_pkg::IDX_W'($urandom),
					                     mco_pkg::IDX_W'($urandom)));
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		$display("Sent %0d words: %0d chains solved, %0d split answers, %0d error words.",
		         words_sent, sb.chains_solved, sb.split_answers, sb.error_words);
		if (sb.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Timeout: results still outstanding");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* matrix_chain_order.f */
sv/mco_pkg.sv
sv/mco_ram.sv
sv/mco_mul.sv
sv/matrix_chain_order.sv
tb/testbench.sv
